[hw/rtl/block_allocation_table_assert.svh]
// Assertion macros shared by the block allocation table RTL.
`ifndef BLOCK_ALLOCATION_TABLE_ASSERT_SVH
`define BLOCK_ALLOCATION_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge while out of reset.
`define BAT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("block allocation table check failed");
// Check that a condition never holds while out of reset.
`define BAT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("block allocation table forbidden condition");
`else
`define BAT_ASSERT(lbl, clk, rstn, prop)
`define BAT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[hw/rtl/bat_pkg.sv]
// Shared types and constants of the block allocation table.
`timescale 1ns / 1ps
package bat_pkg;

  localparam int MaxBlocksDef  = 64;
  localparam int BlockBytesDef = 4096;

  typedef enum logic [3:0] {
    OP_ALLOC      = 4'd0,
    OP_NEXT       = 4'd1,
    OP_SET_BUSY   = 4'd2,
    OP_SET_OFFSET = 4'd3,
    OP_ADVANCE    = 4'd4,
    OP_LOCK       = 4'd5,
    OP_UNLOCK     = 4'd6,
    OP_SET_CACHED = 4'd7,
    OP_READ       = 4'd8
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BUSY      = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

  typedef enum logic {
    CFG_FIRST_BLOCK_ID = 1'b0,
    CFG_BLOCK_COUNT    = 1'b1
  } cfg_index_e;

  // One table entry as kept in the entry memory.
  typedef struct packed {
    logic [31:0] offset;
    logic        busy;
    logic        cached;
    logic [31:0] page;
  } entry_t;

endpackage

[hw/rtl/bat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word and register one read word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/block_allocation_table.sv]
// Block allocation table: entry memory, allocation cursor and op sequencer.
`timescale 1ns / 1ps
// Usage:
//   Configure first_block_id (index 0) and block_count (index 1) through
//   cfg_we_i / cfg_index_i / cfg_wdata_i while the block is idle.
//   Issue a command by raising start with opcode_i, block_id_i,
//   operand_value_i and operand_flag_i; it is taken at an edge where start
//   is high and busy is low. Exactly one result word follows on status_o,
//   found_block_id_o and the entry_*_o ports, marked by the one cycle in
//   which done_o is high. The receiver cannot stall; the word stays on the
//   ports only until the next result replaces it.
//   An accepted command enters the execute state, which uses the entry
//   read through the registered read port of the entry memory; done_o and
//   the result word are registered from there. Allocate stays in that state
//   and scans from the cursor, one entry per cycle, up to MaxBlocks entries.
//   busy drops in the done_o cycle, so a new command can be taken at the
//   edge that ends it; one command is in flight at a time.
//   Reset: a clearing pass zeroes the entry memory, one entry per cycle;
//   busy stays high during it. The cursor and both configuration
//   registers reset to zero.
`include "block_allocation_table_assert.svh"
module block_allocation_table #(
  parameter int MaxBlocks  = bat_pkg::MaxBlocksDef,
  parameter int BlockBytes = bat_pkg::BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  opcode_i,
  input  logic [31:0] block_id_i,
  input  logic [31:0] operand_value_i,
  input  logic        operand_flag_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] found_block_id_o,
  output logic [31:0] entry_offset_out_o,
  output logic        entry_busy_out_o,
  output logic        entry_cached_out_o,
  output logic [31:0] entry_page_out_o
);

  localparam int AddrW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int CurW  = $clog2(MaxBlocks + 1);
  localparam int CntW  = (CurW > 7) ? CurW : 7;
  localparam logic [31:0] BlockSize = 32'(BlockBytes);

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StExec  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [CurW-1:0]  cursor_q, cursor_d;
  logic [31:0]      first_q;
  logic [6:0]       count_q;
  logic [3:0]       op_q;
  logic [31:0]      val_q;
  logic             flag_q;
  logic [AddrW-1:0] idx_q;
  logic             hit_q;

  logic             done_q, done_d;
  logic [1:0]       status_q, status_d;
  logic [31:0]      found_q, found_d;
  logic [31:0]      off_q, off_d;
  logic             ebusy_q, ebusy_d;
  logic             ecached_q, ecached_d;
  logic [31:0]      page_q, page_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  bat_pkg::entry_t  ram_wdata, rd, new_e;

  logic [CntW-1:0]  n_used;
  logic [31:0]      rel;
  logic             hit_in, cur_lt_n, inc_lt_n, room, accept, respond, show;
  logic [CurW-1:0]  cur_inc;
  logic [32:0]      sum;

  // Entry memory
  bat_ram #(
    .Width($bits(bat_pkg::entry_t)),
    .Depth(MaxBlocks)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd)
  );

  // Lookup and cursor compares
  assign n_used   = (CntW'(count_q) > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : CntW'(count_q);
  assign rel      = block_id_i - first_q;
  assign hit_in   = rel < 32'(n_used);
  assign cur_lt_n = CntW'(cursor_q) < n_used;
  assign cur_inc  = cursor_q + 1'b1;
  assign inc_lt_n = CntW'(cur_inc) < n_used;
  assign accept   = start && !busy;
  assign busy     = (state_q != StIdle);

  // Room check and saturating advance on the word just read
  assign room = (rd.offset < BlockSize) && (val_q < (BlockSize - rd.offset));
  assign sum  = {1'b0, rd.offset} + {1'b0, val_q};

  // Modify the addressed entry by opcode
  always_comb begin
    new_e = rd;
    unique case (op_q)
      bat_pkg::OP_SET_BUSY:   new_e.busy = flag_q;
      bat_pkg::OP_SET_OFFSET: new_e.offset = val_q;
      bat_pkg::OP_ADVANCE:    new_e.offset = sum[32] ? '1 : sum[31:0];
      bat_pkg::OP_LOCK:       new_e.busy = 1'b1;
      bat_pkg::OP_UNLOCK:     new_e.busy = 1'b0;
      bat_pkg::OP_SET_CACHED: begin
        new_e.cached = flag_q;
        if (flag_q) begin
          new_e.page = val_q;
        end
      end
      default: new_e = rd;
    endcase
  end

  // Sequence clear, accept and execute
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cursor_d  = cursor_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = new_e;
    ram_raddr = idx_q;
    respond   = 1'b0;
    show      = 1'b0;
    status_d  = bat_pkg::ST_OK;
    found_d   = '0;
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(MaxBlocks - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          state_d   = StExec;
          ram_raddr = (opcode_i == bat_pkg::OP_ALLOC) ? cursor_q[AddrW-1:0]
                                                      : rel[AddrW-1:0];
        end
      end
      StExec: begin
        unique case (op_q)
          bat_pkg::OP_ALLOC: begin
            if (!cur_lt_n) begin
              respond  = 1'b1;
              status_d = bat_pkg::ST_NONE;
            end else if (!rd.busy && room) begin
              ram_we         = 1'b1;
              ram_waddr      = cursor_q[AddrW-1:0];
              ram_wdata      = rd;
              ram_wdata.busy = 1'b1;
              respond        = 1'b1;
              found_d        = first_q + 32'(cursor_q);
            end else begin
              // Step to the next entry, or stop at the block count
              cursor_d = cur_inc;
              if (inc_lt_n) begin
                ram_raddr = cur_inc[AddrW-1:0];
              end else begin
                respond  = 1'b1;
                status_d = bat_pkg::ST_NONE;
              end
            end
          end
          bat_pkg::OP_NEXT: begin
            respond = 1'b1;
            if (cur_lt_n) begin
              found_d  = first_q + 32'(cursor_q);
              cursor_d = cur_inc;
            end else begin
              status_d = bat_pkg::ST_NONE;
            end
          end
          bat_pkg::OP_SET_BUSY, bat_pkg::OP_SET_OFFSET, bat_pkg::OP_ADVANCE,
          bat_pkg::OP_LOCK, bat_pkg::OP_UNLOCK, bat_pkg::OP_SET_CACHED,
          bat_pkg::OP_READ: begin
            respond = 1'b1;
            if (!hit_q) begin
              status_d = bat_pkg::ST_NOT_FOUND;
            end else if ((op_q == bat_pkg::OP_LOCK) && rd.busy) begin
              status_d = bat_pkg::ST_BUSY;
              show     = 1'b1;
            end else begin
              show   = 1'b1;
              ram_we = (op_q != bat_pkg::OP_READ);
            end
          end
          default: respond = 1'b1;
        endcase
        if (respond) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Result word fields
  assign done_d    = respond;
  assign off_d     = show ? new_e.offset : '0;
  assign ebusy_d   = show && new_e.busy;
  assign ecached_d = show && new_e.cached;
  assign page_d    = (show && new_e.cached) ? new_e.page : '0;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      clr_q    <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
      first_q  <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bat_pkg::CFG_FIRST_BLOCK_ID: first_q <= cfg_wdata_i;
          bat_pkg::CFG_BLOCK_COUNT:    count_q <= cfg_wdata_i[6:0];
          default:                     count_q <= count_q;
        endcase
      end
    end
  end

  // Hold the command word and the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      val_q  <= operand_value_i;
      flag_q <= operand_flag_i;
      idx_q  <= rel[AddrW-1:0];
      hit_q  <= hit_in;
    end
    if (respond) begin
      status_q  <= status_d;
      found_q   <= found_d;
      off_q     <= off_d;
      ebusy_q   <= ebusy_d;
      ecached_q <= ecached_d;
      page_q    <= page_d;
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign found_block_id_o   = found_q;
  assign entry_offset_out_o = off_q;
  assign entry_busy_out_o   = ebusy_q;
  assign entry_cached_out_o = ecached_q;
  assign entry_page_out_o   = page_q;

  `BAT_ASSERT(a_accept_goes_busy, clk_i, rst_ni, accept |=> busy)
  `BAT_ASSERT(a_done_after_exec, clk_i, rst_ni, done_o |-> $past(state_q == StExec))
  `BAT_ASSERT(a_cursor_in_range, clk_i, rst_ni, CntW'(cursor_q) <= CntW'(MaxBlocks))
  `BAT_ASSERT_NEVER(a_no_write_idle, clk_i, rst_ni, ram_we && (state_q == StIdle))

endmodule
